// ===== hw/rtl/soau_pkg.sv =====
package soau_pkg;

  localparam int REGISTER_COUNT = 32;
  localparam int REG_IDX_W = $clog2(REGISTER_COUNT);

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // Operand kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_REG  = 2'd1;
  localparam logic [1:0] KIND_IMM  = 2'd2;
  localparam logic [1:0] KIND_MEM  = 2'd3;

  // Actions.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Register sectors (upper nibble of a register code).
  localparam logic [3:0] SECTOR_LOW_BYTE  = 4'h4;
  localparam logic [3:0] SECTOR_HIGH_BYTE = 4'h8;
  localparam logic [3:0] SECTOR_LOW_HALF  = 4'hC;

  // Special registers.
  localparam reg_idx_t REG_LAR = 5'd0;
  localparam reg_idx_t REG_MAR = 5'd1;
  localparam reg_idx_t REG_MBR = 5'd2;
  localparam reg_idx_t REG_DS  = 5'd27;

  // Merge masks for partial register writes.
  localparam logic [31:0] MASK_KEEP_HIGH3 = 32'hFFFF_FF00;
  localparam logic [31:0] MASK_KEEP_MID   = 32'hFFFF_00FF;
  localparam logic [31:0] MASK_KEEP_HIGH2 = 32'hFFFF_0000;

  // Bytes moved by a memory write.
  localparam logic [15:0] WRITE_BYTES = 16'h0004;

  localparam int CFG_INDEX_W = 3;

endpackage

// ===== hw/rtl/soau_ram.sv =====
module soau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/segmented_operand_access_unit.sv =====
// Operand access unit for a segmented virtual machine.
//
// One request on the input channel (in_valid/in_ready) reads or writes one
// operand; exactly one result follows on the output channel
// (out_valid/out_ready). Requests are taken one at a time: in_ready is high
// only while the sequencer is idle. Kind none or immediate goes straight to
// the result; a register operand reads the register file RAM; a memory
// operand reads DS (and its base register), forms the logical address and
// checks it against the segment, ending there on a fault. Otherwise the
// physical address is wrapped by a reciprocal multiplication and a modulo
// step, bytes move through the byte-wide data RAM one byte a cycle, and LAR,
// MAR and MBR are written before the result is registered. The data RAM uses
// a single address for its read and write ports.
// The result sits in an output register, so the next request is accepted
// while it waits; if the receiver is still stalled when that next result is
// ready, the sequencer holds it until the output register is free.
// Synchronous reset clears the register file (through per-entry valid bits),
// the segment table and the sticky fault flag; data memory is not cleared.
// Segment descriptors are written through cfg_wr_en/cfg_index/cfg_data.
module segmented_operand_access_unit #(
  parameter int MEMORY_BYTES  = 16384,
  parameter int SEGMENT_COUNT = 6
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [soau_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [31:0]                           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  action,
  input  logic [1:0]                            operand_kind,
  input  logic [23:0]                           operand_body,
  input  logic [2:0]                            byte_count,
  input  logic [31:0]                           write_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [31:0]                    read_value,
  output logic [31:0]                           logical_address,
  output logic [16:0]                           physical_address,
  output logic                                  segment_fault
);

  localparam int AW    = $clog2(MEMORY_BYTES);
  localparam int PHYS_W = 17;
  localparam int SHIFT = PHYS_W + AW;
  localparam int RW    = PHYS_W + 2;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + MEMORY_BYTES - 1) / MEMORY_BYTES;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  localparam int SI_W  = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_REG   = 14'b00000000000010,
    S_DS    = 14'b00000000000100,
    S_BASE  = 14'b00000000001000,
    S_SUM   = 14'b00000000010000,
    S_TRANS = 14'b00000000100000,
    S_MUL   = 14'b00000001000000,
    S_MOD   = 14'b00000010000000,
    S_MRD   = 14'b00000100000000,
    S_MWR   = 14'b00001000000000,
    S_LAR   = 14'b00010000000000,
    S_MAR   = 14'b00100000000000,
    S_MBR   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state;

  function automatic soau_pkg::reg_idx_t reg_index(input logic [7:0] code);
    if (code[7:4] inside {soau_pkg::SECTOR_LOW_BYTE, soau_pkg::SECTOR_HIGH_BYTE,
                          soau_pkg::SECTOR_LOW_HALF}) begin
      return {1'b0, code[3:0]};
    end
    return code[soau_pkg::REG_IDX_W-1:0];
  endfunction

  // Whole-register codes past the file read as zero and are not written.
  function automatic logic code_ok(input logic [7:0] code);
    if (code[7:4] inside {soau_pkg::SECTOR_LOW_BYTE, soau_pkg::SECTOR_HIGH_BYTE,
                          soau_pkg::SECTOR_LOW_HALF}) begin
      return 1'b1;
    end
    return code[7:soau_pkg::REG_IDX_W] == '0;
  endfunction

  function automatic logic [31:0] part_extract(input logic [7:0] code,
                                               input logic [31:0] word);
    case (code[7:4])
      soau_pkg::SECTOR_LOW_BYTE:  return {24'd0, word[7:0]};
      soau_pkg::SECTOR_HIGH_BYTE: return {24'd0, word[15:8]};
      soau_pkg::SECTOR_LOW_HALF:  return {16'd0, word[15:0]};
      default:                    return word;
    endcase
  endfunction

  function automatic logic [31:0] part_merge(input logic [7:0] code,
                                             input logic [31:0] old,
                                             input logic [31:0] wd);
    case (code[7:4])
      soau_pkg::SECTOR_LOW_BYTE:
        return (old & soau_pkg::MASK_KEEP_HIGH3) | {24'd0, wd[7:0]};
      soau_pkg::SECTOR_HIGH_BYTE:
        return (old & soau_pkg::MASK_KEEP_MID) | {16'd0, wd[7:0], 8'd0};
      soau_pkg::SECTOR_LOW_HALF:
        return (old & soau_pkg::MASK_KEEP_HIGH2) | {16'd0, wd[15:0]};
      default:
        return wd;
    endcase
  endfunction

  // Captured request.
  logic        act_q;
  logic [23:0] body_q;
  logic [2:0]  cnt_q;
  logic [31:0] wdata_q;

  // Working registers.
  logic [15:0]       seg_hi;
  logic [31:0]       base_val;
  logic [31:0]       logical_q;
  logic [16:0]       phys_q;
  logic [31:0]       value_q;
  logic [PHYS_W+RW-1:0] prod_q;
  logic [AW-1:0]     mem_addr;
  logic [2:0]        step;
  logic              fault;

  logic [31:0] seg_tab [SEGMENT_COUNT];

  // Register file RAM with per-entry valid bits.
  logic [soau_pkg::REGISTER_COUNT-1:0] rf_valid;
  soau_pkg::reg_idx_t rf_raddr, rf_waddr;
  logic        rf_we;
  logic [31:0] rf_wdata, rf_q;
  logic        rf_hit;
  logic [31:0] rf_data;

  // Data memory RAM.
  logic          mem_we;
  logic [7:0]    mem_wdata, mem_q;
  logic [AW-1:0] mem_addr_next;

  assign in_ready = (state == S_IDLE);
  assign rf_data  = rf_hit ? rf_q : 32'd0;
  assign mem_addr_next = (mem_addr == AW'(MEMORY_BYTES - 1)) ? '0 : mem_addr + 1'b1;

  soau_ram #(.WIDTH(32), .DEPTH(soau_pkg::REGISTER_COUNT)) u_regfile (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_q)
  );

  soau_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_datamem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (mem_q)
  );

  // Register file port steering.
  always_comb begin
    rf_raddr = soau_pkg::REG_DS;
    if (state == S_IDLE && operand_kind != soau_pkg::KIND_MEM) begin
      rf_raddr = reg_index(operand_body[7:0]);
    end else if (state == S_DS) begin
      rf_raddr = reg_index(body_q[23:16]);
    end

    rf_we    = 1'b0;
    rf_waddr = reg_index(body_q[7:0]);
    rf_wdata = part_merge(body_q[7:0], rf_data, wdata_q);
    case (state)
      S_REG: begin
        rf_we = (act_q == soau_pkg::ACT_WRITE) && code_ok(body_q[7:0]);
      end
      S_LAR: begin
        rf_we    = 1'b1;
        rf_waddr = soau_pkg::REG_LAR;
        rf_wdata = logical_q;
      end
      S_MAR: begin
        rf_we    = 1'b1;
        rf_waddr = soau_pkg::REG_MAR;
        rf_wdata = {(act_q == soau_pkg::ACT_READ) ? {13'd0, cnt_q}
                                                  : soau_pkg::WRITE_BYTES,
                    phys_q[15:0]};
      end
      S_MBR: begin
        rf_we    = 1'b1;
        rf_waddr = soau_pkg::REG_MBR;
        rf_wdata = (act_q == soau_pkg::ACT_READ) ? value_q : wdata_q;
      end
      default: begin
      end
    endcase
  end

  assign mem_we    = (state == S_MWR);
  assign mem_wdata = wdata_q[8 * (3 - step[1:0]) +: 8];

  // Address translation terms.
  logic [15:0]   seg_idx;
  logic [31:0]   desc;
  logic [16:0]   phys_w;
  logic          bad_w;
  logic [16:0]   quot;
  logic [16:0]   qm;
  logic [16:0]   rem_w;

  always_comb begin
    seg_idx = logical_q[31:16];
    desc = (seg_idx < 16'(SEGMENT_COUNT)) ? seg_tab[seg_idx[SI_W-1:0]] : 32'd0;
    phys_w = {1'b0, desc[31:16]} + {1'b0, logical_q[15:0]};
    bad_w  = ({1'b0, phys_w} + 18'd3) > ({2'b0, desc[31:16]} + {2'b0, desc[15:0]});
    quot   = 17'(prod_q >> SHIFT);
    qm     = 17'(quot * 17'(MEMORY_BYTES));
    rem_w  = phys_q - qm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rf_valid  <= '0;
      fault     <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < SEGMENT_COUNT; i++) begin
        seg_tab[i] <= 32'd0;
      end
    end else begin
      if (cfg_wr_en && (32'(cfg_index) < 32'(SEGMENT_COUNT))) begin
        seg_tab[cfg_index[SI_W-1:0]] <= cfg_data;
      end
      if (rf_we) begin
        rf_valid[rf_waddr] <= 1'b1;
      end
      // A result leaving in the same cycle as the next one is loaded is
      // handled in the done state.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (operand_kind)
              soau_pkg::KIND_REG: state <= S_REG;
              soau_pkg::KIND_MEM: state <= S_DS;
              default:            state <= S_DONE;
            endcase
          end
        end
        S_REG: state <= S_DONE;
        S_DS: begin
          state <= (body_q[23:16] != 8'd0) ? S_BASE : S_SUM;
        end
        S_BASE:  state <= S_SUM;
        S_SUM:   state <= S_TRANS;
        S_TRANS: begin
          if (bad_w) begin
            fault <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_MOD;
        S_MOD: state <= (act_q == soau_pkg::ACT_READ) ? S_MRD : S_MWR;
        S_MRD: begin
          if (step == cnt_q) begin
            state <= S_LAR;
          end
        end
        S_MWR: begin
          if (step == 3'd3) begin
            state <= S_LAR;
          end
        end
        S_LAR: state <= S_MAR;
        S_MAR: state <= S_MBR;
        S_MBR: state <= S_DONE;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    rf_hit <= rf_valid[rf_raddr] &&
              ((state == S_IDLE && operand_kind == soau_pkg::KIND_MEM) ||
               (state == S_IDLE && code_ok(operand_body[7:0])) ||
               (state == S_DS && code_ok(body_q[23:16])));

    case (state)
      S_IDLE: begin
        act_q     <= action;
        body_q    <= operand_body;
        cnt_q     <= (byte_count > 3'd4) ? 3'd4 : byte_count;
        wdata_q   <= write_data;
        logical_q <= 32'd0;
        phys_q    <= 17'd0;
        if (operand_kind == soau_pkg::KIND_IMM && action == soau_pkg::ACT_READ) begin
          value_q <= {{16{operand_body[15]}}, operand_body[15:0]};
        end else begin
          value_q <= 32'd0;
        end
      end
      S_REG: begin
        if (act_q == soau_pkg::ACT_READ) begin
          value_q <= part_extract(body_q[7:0], rf_data);
        end
      end
      S_DS: begin
        seg_hi   <= rf_data[31:16];
        base_val <= 32'd0;
      end
      S_BASE: base_val <= part_extract(body_q[23:16], rf_data);
      S_SUM: begin
        logical_q <= {seg_hi, 16'd0} |
                     (base_val + {{16{body_q[15]}}, body_q[15:0]});
      end
      S_TRANS: phys_q <= phys_w;
      S_MUL:   prod_q <= phys_q * RECIP;
      S_MOD: begin
        mem_addr <= rem_w[AW-1:0];
        step     <= 3'd0;
      end
      S_MRD: begin
        // Data read in the previous cycle arrives now, most significant first.
        if (step != 3'd0) begin
          value_q <= {value_q[23:0], mem_q};
        end
        mem_addr <= mem_addr_next;
        step     <= step + 3'd1;
      end
      S_MWR: begin
        mem_addr <= mem_addr_next;
        step     <= step + 3'd1;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          read_value       <= $signed(value_q);
          logical_address  <= logical_q;
          physical_address <= phys_q;
          segment_fault    <= fault;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
